FILE: hw/rtl/ngso_pkg.sv
`default_nettype none

package ngso_pkg;

  // stream and config port widths
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE   = 2'd1;

  localparam logic [17:0] RATE_RESET  = 18'd48000;
  localparam logic [15:0] AMP_RESET   = 16'd8192;
  localparam logic [14:0] TONE_RESET  = 15'd7040;
  localparam logic [14:0] FREQ_MIN    = 15'd640;
  localparam logic [14:0] FREQ_MAX    = 15'd32000;
  localparam logic [15:0] FULL_SCALE  = 16'd32768;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [31:0] SINE_PEAK   = 32'd32767;

  // Taylor term divisors and their reciprocals: q ~ (n * MULT) >> SHIFT, off by at most one
  localparam int DIV_SHIFT_72 = 38;
  localparam int DIV_SHIFT_42 = 37;
  localparam int DIV_SHIFT_20 = 36;
  localparam int DIV_SHIFT_6  = 34;
  localparam logic [31:0] DIV_MULT_72 = 32'((64'd1 << DIV_SHIFT_72) / 64'd72);
  localparam logic [31:0] DIV_MULT_42 = 32'((64'd1 << DIV_SHIFT_42) / 64'd42);
  localparam logic [31:0] DIV_MULT_20 = 32'((64'd1 << DIV_SHIFT_20) / 64'd20);
  localparam logic [31:0] DIV_MULT_6  = 32'((64'd1 << DIV_SHIFT_6) / 64'd6);

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_NOTE_ON  = 2'd1,
    MODE_NOTE_OFF = 2'd2,
    MODE_SET_FREQ = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_X_MUL,
    OP_X_WB,
    OP_X2_MUL,
    OP_X2_WB,
    OP_D_MUL,
    OP_D_Q,
    OP_D_QD,
    OP_D_FIX,
    OP_T_MUL,
    OP_T_WB,
    OP_S_MUL,
    OP_S_WB,
    OP_MAG_MUL,
    OP_MAG_WB,
    OP_G_MUL,
    OP_G_WB,
    OP_M_MUL,
    OP_M_WB
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_X_MUL,
    ST_X_WB,
    ST_X2_MUL,
    ST_X2_WB,
    ST_D_MUL,
    ST_D_Q,
    ST_D_QD,
    ST_D_FIX,
    ST_T_MUL,
    ST_T_WB,
    ST_S_MUL,
    ST_S_WB,
    ST_MAG_MUL,
    ST_MAG_WB,
    ST_G_MUL,
    ST_G_WB,
    ST_M_MUL,
    ST_M_WB,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] term;
    logic       load;
    logic       div_start;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  gate_on;
    logic  rate_changed;
    logic  div_busy;
    logic  out_free;
  } status_t;

  typedef logic [0:127][14:0] note_rom_t;

  localparam logic [0:11][21:0] OCTAVE_ROM = '{
    22'd1802240, 22'd1909407, 22'd2022946, 22'd2143237, 22'd2270680, 22'd2405702,
    22'd2548752, 22'd2700309, 22'd2860878, 22'd3030994, 22'd3211227, 22'd3402176
  };

  // equal-tempered note table, built at elaboration
  function automatic note_rom_t note_rom_build();
    note_rom_t   rom;
    int          d;
    int          oct;
    int          k;
    int          sh;
    logic [63:0] v;
    logic [63:0] f;
    for (int n = 0; n < 128; n++) begin
      d = n + 3;
      oct = d / 12;
      k = d % 12;
      v = 64'(OCTAVE_ROM[k]);
      if (oct >= 6) begin
        v = v << (oct - 6);
        f = (v + 64'd128) >> 8;
      end else begin
        sh = 14 - oct;
        f = (v + (64'd1 << (sh - 1))) >> sh;
      end
      if (f > 64'(FREQ_MAX)) f = 64'(FREQ_MAX);
      if (f < 64'(FREQ_MIN)) f = 64'(FREQ_MIN);
      rom[n] = 15'(f);
    end
    return rom;
  endfunction

  function automatic logic [14:0] clamp_freq(input logic [15:0] f);
    logic [14:0] r;
    if (f < 16'(FREQ_MIN)) r = FREQ_MIN;
    else if (f > 16'(FREQ_MAX)) r = FREQ_MAX;
    else r = f[14:0];
    return r;
  endfunction

  function automatic logic [15:0] sat_full_scale(input logic [15:0] v);
    return (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

  function automatic logic [6:0] div_const(input logic [1:0] term);
    logic [6:0] d;
    case (term)
      2'd0: d = 7'd72;
      2'd1: d = 7'd42;
      2'd2: d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] div_mult(input logic [1:0] term);
    logic [31:0] m;
    case (term)
      2'd0: m = DIV_MULT_72;
      2'd1: m = DIV_MULT_42;
      2'd2: m = DIV_MULT_20;
      default: m = DIV_MULT_6;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ngso_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle:
// quo = ((freq << PHASE_BITS) + 8*rate) / (16*rate), low PHASE_BITS bits kept
module ngso_div #(
  parameter int PHASE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [14:0]           freq,
  input  wire logic [17:0]           rate,
  output logic                       busy,
  output logic                       done,
  output logic [PHASE_BITS-1:0]      quo
);

  localparam int DW = PHASE_BITS + 16;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [21:0]   den;
  logic [21:0]   rem;
  logic [CW-1:0] cnt;
  logic [22:0]   trial;
  logic [22:0]   diff;
  logic          ge;

  assign trial = {rem, dvd[DW-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= DW'({freq, {PHASE_BITS{1'b0}}}) + DW'({rate, 3'b000});
      den <= {rate, 4'b0000};
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      rem <= ge ? diff[21:0] : trial[21:0];
      quo <= {quo[PHASE_BITS-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ngso_datapath.sv
`default_nettype none

module ngso_datapath #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ngso_pkg::cmd_t                     cmd,
  output ngso_pkg::status_t                       status,
  input  wire logic [ngso_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire logic [ngso_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  input  wire logic                               m_axis_tready,
  output logic                                    m_axis_tvalid,
  output logic [ngso_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [ngso_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ngso_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int QB = SINE_TABLE_BITS - 2;
  localparam logic [QB:0] QUARTER = {1'b1, {QB{1'b0}}};
  localparam logic [PHASE_BITS-1:0] STEP_RESET = PHASE_BITS'(
    ((64'(ngso_pkg::TONE_RESET) << PHASE_BITS) + 64'(ngso_pkg::RATE_RESET) * 64'd8)
    / (64'(ngso_pkg::RATE_RESET) * 64'd16));
  localparam ngso_pkg::note_rom_t NOTE_ROM = ngso_pkg::note_rom_build();

  // config and tone state
  logic [17:0]           sample_rate;
  logic [15:0]           amplitude;
  logic [14:0]           tone_frequency;
  logic                  gate_on;
  logic [15:0]           note_velocity;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_step;
  logic                  rate_changed;

  // sine evaluation registers
  logic [63:0]        prod;
  logic [31:0]        x;
  logic [31:0]        x2;
  logic [31:0]        n_val;
  logic [31:0]        q;
  logic [31:0]        t;
  logic [14:0]        mag;
  logic [15:0]        gain;
  logic signed [15:0] smp;
  logic signed [15:0] mix;

  logic                  div_busy;
  logic                  div_done;
  logic [PHASE_BITS-1:0] div_quo;

  logic [6:0]  in_note;
  logic [15:0] in_vel;
  logic [15:0] in_freq;
  logic [15:0] in_mix;
  logic        rate_write;

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QB:0]                quarter_r;
  logic [31:0]                mul_a;
  logic [31:0]                mul_b;
  logic [31:0]                q_est;
  logic [31:0]                rem_val;
  logic [31:0]                q_fix;
  logic [47:0]                mag_round;
  logic [31:0]                gain_round;
  logic [31:0]                m_round;
  logic [15:0]                m_ext;
  logic signed [16:0]         sum;
  logic signed [15:0]         mixed;

  assign in_note = s_axis_tdata[6:0];
  assign in_vel  = s_axis_tdata[22:7];
  assign in_freq = s_axis_tdata[38:23];
  assign in_mix  = s_axis_tdata[54:39];

  assign rate_write = cfg_we && (cfg_index == ngso_pkg::REG_SAMPLE_RATE) && (cfg_wdata != '0);

  assign idx  = phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign quarter_r = quad[0] ? (QUARTER - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};

  always_comb begin
    case (cmd.op)
      ngso_pkg::OP_X_MUL: begin
        mul_a = 32'(quarter_r);
        mul_b = ngso_pkg::HALF_PI_Q30;
      end
      ngso_pkg::OP_X2_MUL: begin
        mul_a = x;
        mul_b = x;
      end
      ngso_pkg::OP_D_MUL: begin
        mul_a = n_val;
        mul_b = ngso_pkg::div_mult(cmd.term);
      end
      ngso_pkg::OP_D_QD: begin
        mul_a = q;
        mul_b = 32'(ngso_pkg::div_const(cmd.term));
      end
      ngso_pkg::OP_T_MUL: begin
        mul_a = x2;
        mul_b = t;
      end
      ngso_pkg::OP_S_MUL: begin
        mul_a = x;
        mul_b = t;
      end
      ngso_pkg::OP_MAG_MUL: begin
        mul_a = n_val;
        mul_b = ngso_pkg::SINE_PEAK;
      end
      ngso_pkg::OP_G_MUL: begin
        mul_a = 32'(amplitude);
        mul_b = 32'(note_velocity);
      end
      ngso_pkg::OP_M_MUL: begin
        mul_a = 32'(mag);
        mul_b = 32'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.term)
      2'd0: q_est = 32'(prod >> ngso_pkg::DIV_SHIFT_72);
      2'd1: q_est = 32'(prod >> ngso_pkg::DIV_SHIFT_42);
      2'd2: q_est = 32'(prod >> ngso_pkg::DIV_SHIFT_20);
      default: q_est = 32'(prod >> ngso_pkg::DIV_SHIFT_6);
    endcase
  end

  // reciprocal estimate is at most one low
  assign rem_val = n_val - prod[31:0];
  assign q_fix   = q + 32'(rem_val >= 32'(ngso_pkg::div_const(cmd.term)));

  assign mag_round  = prod[47:0] + 48'(64'd1 << 29);
  assign gain_round = prod[31:0] + 32'd16384;
  assign m_round    = prod[31:0] + 32'd16384;
  assign m_ext      = {1'b0, m_round[29:15]};

  assign sum = 17'(mix) + 17'(smp);
  always_comb begin
    if (sum > 17'sd32767) mixed = 16'sh7FFF;
    else if (sum < -17'sd32768) mixed = 16'sh8000;
    else mixed = sum[15:0];
  end

  ngso_div #(
    .PHASE_BITS(PHASE_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .freq (tone_frequency),
    .rate (sample_rate),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate    <= ngso_pkg::RATE_RESET;
      amplitude      <= ngso_pkg::AMP_RESET;
      tone_frequency <= ngso_pkg::TONE_RESET;
      gate_on        <= 1'b0;
      note_velocity  <= '0;
      phase_acc      <= '0;
      phase_step     <= STEP_RESET;
      rate_changed   <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ngso_pkg::REG_SAMPLE_RATE: begin
            if (cfg_wdata != '0) sample_rate <= cfg_wdata;
          end
          ngso_pkg::REG_AMPLITUDE: amplitude <= ngso_pkg::sat_full_scale(cfg_wdata[15:0]);
          default: ;
        endcase
      end

      if (rate_write) rate_changed <= 1'b1;
      else if (cmd.div_start) rate_changed <= 1'b0;

      if (cmd.load) begin
        case (ngso_pkg::mode_t'(s_axis_tuser))
          ngso_pkg::MODE_NOTE_ON: begin
            gate_on        <= 1'b1;
            note_velocity  <= ngso_pkg::sat_full_scale(in_vel);
            tone_frequency <= NOTE_ROM[in_note];
          end
          ngso_pkg::MODE_NOTE_OFF: gate_on <= 1'b0;
          ngso_pkg::MODE_SET_FREQ: tone_frequency <= ngso_pkg::clamp_freq(in_freq);
          default: ;
        endcase
      end

      if (div_done) phase_step <= div_quo;

      if (cmd.out_load) begin
        phase_acc     <= phase_acc + phase_step;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    if (cmd.load) begin
      mix <= in_mix;
      smp <= '0;
    end
    if (cmd.out_load) m_axis_tdata <= {mixed, smp};
    case (cmd.op)
      ngso_pkg::OP_X_WB: x <= 32'(prod >> QB);
      ngso_pkg::OP_X2_WB: begin
        x2    <= prod[61:30];
        n_val <= prod[61:30];
      end
      ngso_pkg::OP_D_Q: q <= q_est;
      ngso_pkg::OP_D_FIX: t <= ngso_pkg::Q30_ONE - q_fix;
      ngso_pkg::OP_T_WB: n_val <= prod[61:30];
      ngso_pkg::OP_S_WB: n_val <= prod[61:30];
      ngso_pkg::OP_MAG_WB: begin
        if (mag_round[47:30] > 18'd32767) mag <= 15'h7FFF;
        else mag <= mag_round[44:30];
      end
      ngso_pkg::OP_G_WB: gain <= gain_round[30:15];
      ngso_pkg::OP_M_WB: smp <= quad[1] ? (16'd0 - m_ext) : m_ext;
      default: ;
    endcase
  end

  always_comb begin
    status.mode         = ngso_pkg::mode_t'(s_axis_tuser);
    status.gate_on      = gate_on;
    status.rate_changed = rate_changed;
    status.div_busy     = div_busy;
    status.out_free     = !m_axis_tvalid || m_axis_tready;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ngso_ctrl.sv
`default_nettype none

module ngso_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire ngso_pkg::status_t status,
  output ngso_pkg::cmd_t         cmd
);

  ngso_pkg::state_t state;
  ngso_pkg::state_t state_next;
  logic [1:0]       term;
  logic [1:0]       term_next;
  logic             accept;

  assign s_axis_tready = (state == ngso_pkg::ST_IDLE) && !status.rate_changed;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ngso_pkg::ST_IDLE;
      term  <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

  always_comb begin
    state_next = state;
    term_next  = term;
    case (state)
      ngso_pkg::ST_IDLE: begin
        if (status.rate_changed) begin
          state_next = ngso_pkg::ST_DIV_START;
        end else if (accept) begin
          case (status.mode)
            ngso_pkg::MODE_TICK:
              state_next = status.gate_on ? ngso_pkg::ST_X_MUL : ngso_pkg::ST_OUT;
            ngso_pkg::MODE_NOTE_ON, ngso_pkg::MODE_SET_FREQ:
              state_next = ngso_pkg::ST_DIV_START;
            default: state_next = ngso_pkg::ST_IDLE;
          endcase
        end
      end
      ngso_pkg::ST_DIV_START: state_next = ngso_pkg::ST_DIV_WAIT;
      ngso_pkg::ST_DIV_WAIT: begin
        if (!status.div_busy) state_next = ngso_pkg::ST_IDLE;
      end
      ngso_pkg::ST_X_MUL:  state_next = ngso_pkg::ST_X_WB;
      ngso_pkg::ST_X_WB:   state_next = ngso_pkg::ST_X2_MUL;
      ngso_pkg::ST_X2_MUL: state_next = ngso_pkg::ST_X2_WB;
      ngso_pkg::ST_X2_WB: begin
        state_next = ngso_pkg::ST_D_MUL;
        term_next  = '0;
      end
      ngso_pkg::ST_D_MUL: state_next = ngso_pkg::ST_D_Q;
      ngso_pkg::ST_D_Q:   state_next = ngso_pkg::ST_D_QD;
      ngso_pkg::ST_D_QD:  state_next = ngso_pkg::ST_D_FIX;
      ngso_pkg::ST_D_FIX:
        state_next = (term == 2'd3) ? ngso_pkg::ST_S_MUL : ngso_pkg::ST_T_MUL;
      ngso_pkg::ST_T_MUL: state_next = ngso_pkg::ST_T_WB;
      ngso_pkg::ST_T_WB: begin
        state_next = ngso_pkg::ST_D_MUL;
        term_next  = term + 2'd1;
      end
      ngso_pkg::ST_S_MUL:   state_next = ngso_pkg::ST_S_WB;
      ngso_pkg::ST_S_WB:    state_next = ngso_pkg::ST_MAG_MUL;
      ngso_pkg::ST_MAG_MUL: state_next = ngso_pkg::ST_MAG_WB;
      ngso_pkg::ST_MAG_WB:  state_next = ngso_pkg::ST_G_MUL;
      ngso_pkg::ST_G_MUL:   state_next = ngso_pkg::ST_G_WB;
      ngso_pkg::ST_G_WB:    state_next = ngso_pkg::ST_M_MUL;
      ngso_pkg::ST_M_MUL:   state_next = ngso_pkg::ST_M_WB;
      ngso_pkg::ST_M_WB:    state_next = ngso_pkg::ST_OUT;
      ngso_pkg::ST_OUT: begin
        if (status.out_free) state_next = ngso_pkg::ST_IDLE;
      end
      default: state_next = ngso_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.term      = term;
    cmd.load      = accept;
    cmd.div_start = (state == ngso_pkg::ST_DIV_START);
    cmd.out_load  = (state == ngso_pkg::ST_OUT) && status.out_free;
    case (state)
      ngso_pkg::ST_X_MUL:   cmd.op = ngso_pkg::OP_X_MUL;
      ngso_pkg::ST_X_WB:    cmd.op = ngso_pkg::OP_X_WB;
      ngso_pkg::ST_X2_MUL:  cmd.op = ngso_pkg::OP_X2_MUL;
      ngso_pkg::ST_X2_WB:   cmd.op = ngso_pkg::OP_X2_WB;
      ngso_pkg::ST_D_MUL:   cmd.op = ngso_pkg::OP_D_MUL;
      ngso_pkg::ST_D_Q:     cmd.op = ngso_pkg::OP_D_Q;
      ngso_pkg::ST_D_QD:    cmd.op = ngso_pkg::OP_D_QD;
      ngso_pkg::ST_D_FIX:   cmd.op = ngso_pkg::OP_D_FIX;
      ngso_pkg::ST_T_MUL:   cmd.op = ngso_pkg::OP_T_MUL;
      ngso_pkg::ST_T_WB:    cmd.op = ngso_pkg::OP_T_WB;
      ngso_pkg::ST_S_MUL:   cmd.op = ngso_pkg::OP_S_MUL;
      ngso_pkg::ST_S_WB:    cmd.op = ngso_pkg::OP_S_WB;
      ngso_pkg::ST_MAG_MUL: cmd.op = ngso_pkg::OP_MAG_MUL;
      ngso_pkg::ST_MAG_WB:  cmd.op = ngso_pkg::OP_MAG_WB;
      ngso_pkg::ST_G_MUL:   cmd.op = ngso_pkg::OP_G_MUL;
      ngso_pkg::ST_G_WB:    cmd.op = ngso_pkg::OP_G_WB;
      ngso_pkg::ST_M_MUL:   cmd.op = ngso_pkg::OP_M_MUL;
      ngso_pkg::ST_M_WB:    cmd.op = ngso_pkg::OP_M_WB;
      default:              cmd.op = ngso_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/note_gated_sine_oscillator.sv
`default_nettype none

// Gated sine oscillator (direct digital synthesis). Each input transfer carries a kind
// in tuser: tick, note on, note off or set frequency. Only a tick returns a result: the
// Q1.15 sine sample, scaled by amplitude*velocity while the gate is open, and that sample
// added to mix_in with saturation. The sine is evaluated per tick by a degree-9 odd
// polynomial on one shared 32x32 multiplier, so a tick with the gate open steps through the
// multiply and write-back states before its result is raised; with the gate closed the
// tick goes straight to the output state. Note on and set frequency run the bit-serial
// phase-step divider, PHASE_BITS+16 iterations; note off only updates the gate. A write
// of a nonzero sample_rate starts the same divider and holds off input until it is done.
// A finished result waits in the output register while the next item is being worked on.
module note_gated_sine_oscillator #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // note[6:0], velocity[22:7], frequency_value[38:23], mix_in[54:39], zero[55]
  input  wire logic [ngso_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  wire logic [ngso_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // sample[15:0], mixed_out[31:16]
  output logic [ngso_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [ngso_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ngso_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ngso_pkg::cmd_t    cmd;
  ngso_pkg::status_t status;

  ngso_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .status       (status),
    .cmd          (cmd)
  );

  ngso_datapath #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .PHASE_BITS     (PHASE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tready(m_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/ngso_checker.sv
`default_nettype none

module ngso_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [ngso_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [ngso_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                             cfg_we,
  input wire logic [ngso_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic [ngso_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // only note off leaves the block ready right after its transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != ngso_pkg::MODE_NOTE_OFF)
    |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_no_result_from_control: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != ngso_pkg::MODE_TICK)
    |=> !$rose(m_axis_tvalid))
    else $error("result raised by a non-tick item");

  a_rate_write_stalls: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == ngso_pkg::REG_SAMPLE_RATE) && (cfg_wdata != '0)
    |=> !s_axis_tready)
    else $error("input taken before phase step recompute");

endmodule

bind note_gated_sine_oscillator ngso_checker u_checker (.*);

`default_nettype wire
